/* rtl/brb_pkg.sv */
// Shared types and constants for the byte ring buffer.
`default_nettype none

package brb_pkg;

    // Store geometry
    localparam int DEPTH     = 1024;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SIZE_W    = ADDR_W + 1;
    localparam int MAX_BURST = 64;
    localparam int BURST_W   = $clog2(MAX_BURST + 1);

    // Field widths
    localparam int CMD_W  = 3;
    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CAP_W   = 11;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE    = 3'd0,
        CMD_DEQUEUE    = 3'd1,
        CMD_PEEK       = 3'd2,
        CMD_MOVE_FRONT = 3'd3,
        CMD_MOVE_REAR  = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_STATUS     = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOD,
        ST_MOVE_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/byte_ring_buffer_core.sv */
// Byte ring buffer: circular byte FIFO with one slot reserved, APB capacity register.
// Enqueue, clear, status and rejected reads answer in the cycle after the request;
// dequeue/peek pass through ST_READ, the store read register and the output register.
// Enqueue takes one byte per cycle while the output slot is free; a burst holds the input
// until its last byte is loaded; a move runs 11 remainder steps, then one commit, and holds it until then.
// Reset: pointers and enqueue state cleared, capacity 1024; store undefined, no clearing pass.
`default_nettype none

module byte_ring_buffer_core (
    input  wire                              clk,
    input  wire                              rst_n,
    // APB configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [brb_pkg::PADDR_W-1:0]      paddr,
    input  wire  [brb_pkg::PDATA_W-1:0]      pwdata,
    output logic [brb_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    // Request stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [brb_pkg::S_TDATA_W-1:0]    s_tdata,  // length[9:0], data_byte[17:10], zero pad
    input  wire  [brb_pkg::CMD_W-1:0]        s_tuser,  // command[2:0]
    input  wire                              s_tlast,  // last
    // Result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]    m_tdata,  // out_byte[7:0], count[17:8],
                                                       // used_bytes[27:18], free_bytes[37:28],
                                                       // direct_enqueue[47:38],
                                                       // direct_dequeue[57:48], zero pad
    output logic                             m_tlast   // end_of_run
);
    import brb_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   capacity_reg;
    logic [ADDR_W-1:0]  front_reg, front_next;
    logic [ADDR_W-1:0]  rear_reg, rear_next;

    // Open enqueue request
    logic               req_open_reg, req_open_next;
    logic               req_acc_reg, req_acc_next;
    logic [LEN_W-1:0]   req_len_reg, req_len_next;
    logic [LEN_W-1:0]   bw_reg, bw_next;

    // Burst read
    logic [BURST_W-1:0] burst_len_reg, burst_len_next;
    logic               burst_deq_reg, burst_deq_next;
    logic [BURST_W-1:0] rd_idx_reg, rd_idx_next;
    logic [BURST_W-1:0] emit_idx_reg, emit_idx_next;
    logic               rd_valid_reg, rd_valid_next;

    // Pointer move: bit-serial remainder of (pointer + length) by ring size
    logic [LEN_W-1:0]   move_len_reg, move_len_next;
    logic               move_rear_reg, move_rear_next;
    logic [SIZE_W-1:0]  div_sum_reg, div_sum_next;
    logic [SIZE_W-1:0]  rem_reg, rem_next;
    logic [3:0]         step_reg, step_next;

    // Output register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic               eor_reg, eor_next;
    logic [LEN_W-1:0]   used_reg, used_next;
    logic [LEN_W-1:0]   free_reg, free_next;
    logic [LEN_W-1:0]   de_reg, de_next;
    logic [LEN_W-1:0]   dd_reg, dd_next;
    logic               out_load;

    // Store
    logic [BYTE_W-1:0]  mem [DEPTH];
    logic [BYTE_W-1:0]  mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               rd_issue;
    logic [ADDR_W-1:0]  rd_addr;

    // ------------------------------------------------------------------
    // Request fields and handshakes
    // ------------------------------------------------------------------
    cmd_t               cmd;
    logic [LEN_W-1:0]   length_in;
    logic [BYTE_W-1:0]  data_in;
    logic               accept;
    logic               out_free;
    logic               cfg_we;

    assign cmd       = cmd_t'(s_tuser);
    assign length_in = s_tdata[LEN_W-1:0];
    assign data_in   = s_tdata[LEN_W +: BYTE_W];

    // The output slot is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ?
                    {{(PDATA_W-CAP_W){1'b0}}, capacity_reg} : '0;

    // ------------------------------------------------------------------
    // Ring size and occupancy
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  ring_n;
    logic [SIZE_W-1:0]  front_x, rear_x;
    logic [SIZE_W-1:0]  used_w, free_w;
    logic [SIZE_W-1:0]  de_w, dd_w;
    logic [LEN_W-1:0]   used_c, free_c;

    // Clamp the configured capacity into [2, DEPTH].
    always_comb
    begin
        priority if (capacity_reg < CAP_W'(2))
            ring_n = SIZE_W'(2);
        else if (capacity_reg > CAP_W'(DEPTH))
            ring_n = SIZE_W'(DEPTH);
        else
            ring_n = SIZE_W'(capacity_reg);
    end

    assign front_x = {1'b0, front_reg};
    assign rear_x  = {1'b0, rear_reg};

    always_comb
    begin
        if (rear_reg >= front_reg)
            used_w = rear_x - front_x;
        else
            used_w = ring_n - front_x + rear_x;
        free_w = ring_n - used_w - SIZE_W'(1);
        if (rear_reg >= front_reg)
            de_w = (front_reg == '0) ? (ring_n - rear_x - SIZE_W'(1)) : (ring_n - rear_x);
        else
            de_w = free_w;
        dd_w = (rear_reg < front_reg) ? (ring_n - front_x) : used_w;
    end

    assign used_c = used_w[LEN_W-1:0];
    assign free_c = free_w[LEN_W-1:0];

    // Wrap a sum that is known to stay below twice the ring size.
    function automatic logic [ADDR_W-1:0] wrap(input logic [SIZE_W-1:0] sum,
                                                 input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] r;
        r = (sum >= n) ? (sum - n) : sum;
        return r[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Enqueue bookkeeping for the current byte
    // ------------------------------------------------------------------
    logic               enq_acc;
    logic [LEN_W-1:0]   enq_len;
    logic [LEN_W-1:0]   enq_bw;
    logic               enq_write;
    logic [LEN_W-1:0]   enq_bw_inc;
    logic [LEN_W-1:0]   enq_cnt;

    // A byte seen with no request open starts one and samples the length.
    assign enq_len    = req_open_reg ? req_len_reg : length_in;
    assign enq_acc    = req_open_reg ? req_acc_reg : (free_c >= length_in);
    assign enq_bw     = req_open_reg ? bw_reg : '0;
    assign enq_write  = enq_acc && (enq_bw < enq_len);
    assign enq_bw_inc = enq_bw + LEN_W'(enq_write);
    assign enq_cnt    = enq_acc ? enq_bw_inc : '0;

    // ------------------------------------------------------------------
    // Burst read control
    // ------------------------------------------------------------------
    logic               rd_load;
    logic               rd_last;
    logic               burst_ok;
    logic [SIZE_W-1:0]  trial;

    assign rd_load  = (state_reg == ST_READ) && rd_valid_reg && out_free;
    assign rd_last  = (emit_idx_reg + BURST_W'(1)) == burst_len_reg;
    assign rd_issue = (state_reg == ST_READ) && (rd_idx_reg < burst_len_reg)
                      && (!rd_valid_reg || rd_load);
    assign rd_addr  = wrap(front_x + SIZE_W'(rd_idx_reg), ring_n);
    assign burst_ok = (length_in != '0) && (length_in <= LEN_W'(MAX_BURST))
                      && (length_in <= used_c);

    // One restoring step of the remainder unit.
    assign trial = {rem_reg[SIZE_W-2:0], div_sum_reg[SIZE_W-1]};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd == CMD_DEQUEUE || cmd == CMD_PEEK) && burst_ok)
                        state_next = ST_READ;
                    else if (cmd == CMD_MOVE_FRONT || cmd == CMD_MOVE_REAR)
                        state_next = ST_MOD;
                end
            end
            ST_READ:
            begin
                if (rd_load && rd_last)
                    state_next = ST_IDLE;
            end
            ST_MOD:
            begin
                if (step_reg == 4'(SIZE_W - 1))
                    state_next = ST_MOVE_DONE;
            end
            ST_MOVE_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        req_open_next  = req_open_reg;
        req_acc_next   = req_acc_reg;
        req_len_next   = req_len_reg;
        bw_next        = bw_reg;
        burst_len_next = burst_len_reg;
        burst_deq_next = burst_deq_reg;
        rd_idx_next    = rd_idx_reg;
        emit_idx_next  = emit_idx_reg;
        rd_valid_next  = rd_valid_reg;
        move_len_next  = move_len_reg;
        move_rear_next = move_rear_reg;
        div_sum_next   = div_sum_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        mem_we         = 1'b0;
        mem_waddr      = wrap(rear_x + SIZE_W'(enq_bw), ring_n);
        out_load       = 1'b0;
        out_byte_next  = '0;
        count_next     = '0;
        eor_next       = 1'b1;
        used_next      = '0;
        free_next      = '0;
        de_next        = '0;
        dd_next        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Any command but enqueue abandons an open request.
                    if (cmd != CMD_ENQUEUE)
                    begin
                        req_open_next = 1'b0;
                        req_acc_next  = 1'b0;
                        bw_next       = '0;
                    end
                    unique case (cmd)
                        CMD_ENQUEUE:
                        begin
                            mem_we = enq_write;
                            if (s_tlast)
                            begin
                                rear_next     = wrap(rear_x + SIZE_W'(enq_cnt), ring_n);
                                req_open_next = 1'b0;
                                req_acc_next  = 1'b0;
                                bw_next       = '0;
                                out_load      = 1'b1;
                                count_next    = enq_cnt;
                            end
                            else
                            begin
                                req_open_next = 1'b1;
                                req_acc_next  = enq_acc;
                                req_len_next  = enq_len;
                                bw_next       = enq_bw_inc;
                            end
                        end
                        CMD_DEQUEUE, CMD_PEEK:
                        begin
                            if (burst_ok)
                            begin
                                burst_len_next = BURST_W'(length_in);
                                burst_deq_next = (cmd == CMD_DEQUEUE);
                                rd_idx_next    = '0;
                                emit_idx_next  = '0;
                                rd_valid_next  = 1'b0;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        CMD_MOVE_FRONT, CMD_MOVE_REAR:
                        begin
                            move_len_next  = length_in;
                            move_rear_next = (cmd == CMD_MOVE_REAR);
                            div_sum_next   = ((cmd == CMD_MOVE_REAR) ? rear_x : front_x)
                                             + SIZE_W'(length_in);
                            rem_next       = '0;
                            step_next      = '0;
                        end
                        CMD_CLEAR:
                        begin
                            front_next = '0;
                            rear_next  = '0;
                            out_load   = 1'b1;
                        end
                        CMD_STATUS:
                        begin
                            out_load  = 1'b1;
                            used_next = used_c;
                            free_next = free_c;
                            de_next   = de_w[LEN_W-1:0];
                            dd_next   = dd_w[LEN_W-1:0];
                        end
                        default:
                        begin
                            // Unused command: no result.
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (rd_issue)
                    rd_idx_next = rd_idx_reg + BURST_W'(1);
                if (rd_issue)
                    rd_valid_next = 1'b1;
                else if (rd_load)
                    rd_valid_next = 1'b0;
                if (rd_load)
                begin
                    out_load      = 1'b1;
                    out_byte_next = mem_rdata_reg;
                    count_next    = LEN_W'(burst_len_reg);
                    eor_next      = rd_last;
                    emit_idx_next = emit_idx_reg + BURST_W'(1);
                    if (rd_last && burst_deq_reg)
                        front_next = wrap(front_x + SIZE_W'(burst_len_reg), ring_n);
                end
            end
            ST_MOD:
            begin
                rem_next     = (trial >= ring_n) ? (trial - ring_n) : trial;
                div_sum_next = {div_sum_reg[SIZE_W-2:0], 1'b0};
                step_next    = step_reg + 4'd1;
            end
            ST_MOVE_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    count_next = move_len_reg;
                    if (move_rear_reg)
                        rear_next = rem_reg[ADDR_W-1:0];
                    else
                        front_next = rem_reg[ADDR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            front_reg     <= '0;
            rear_reg      <= '0;
            req_open_reg  <= 1'b0;
            req_acc_reg   <= 1'b0;
            bw_reg        <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            emit_idx_reg  <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg   <= rd_idx_next;
            emit_idx_reg <= emit_idx_next;
            step_reg     <= step_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            // A capacity write resets the ring and drops any open request.
            if (cfg_we)
            begin
                capacity_reg <= pwdata[CAP_W-1:0];
                front_reg    <= '0;
                rear_reg     <= '0;
                req_open_reg <= 1'b0;
                req_acc_reg  <= 1'b0;
                bw_reg       <= '0;
            end
            else
            begin
                front_reg    <= front_next;
                rear_reg     <= rear_next;
                req_open_reg <= req_open_next;
                req_acc_reg  <= req_acc_next;
                bw_reg       <= bw_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_len_reg   <= req_len_next;
        burst_len_reg <= burst_len_next;
        burst_deq_reg <= burst_deq_next;
        move_len_reg  <= move_len_next;
        move_rear_reg <= move_rear_next;
        div_sum_reg   <= div_sum_next;
        rem_reg       <= rem_next;
        if (out_load)
        begin
            out_byte_reg <= out_byte_next;
            count_reg    <= count_next;
            eor_reg      <= eor_next;
            used_reg     <= used_next;
            free_reg     <= free_next;
            de_reg       <= de_next;
            dd_reg       <= dd_next;
        end
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= data_in;
        if (rd_issue)
            mem_rdata_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = eor_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - 5*LEN_W){1'b0}},
                       dd_reg, de_reg, free_reg, used_reg, count_reg, out_byte_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (front_x < ring_n) && (rear_x < ring_n))
        else $error("ring pointer outside ring size");

    a_rd_stage_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |->
            (rd_idx_reg == emit_idx_reg + BURST_W'(rd_valid_reg)))
        else $error("read stage out of step with issue and emit counters");

    a_rd_valid_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_READ))
        else $error("read data pending outside a burst");

    a_enq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        req_open_reg |-> (bw_reg <= req_len_reg))
        else $error("enqueue wrote past its request length");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD || state_reg == ST_MOVE_DONE) |-> (rem_reg < ring_n))
        else $error("remainder unit left its range");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for byte_ring_buffer_core: stream requests predicted and compared.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brb_pkg::*;

    // Command 7 has no meaning; the core must drop it and still abandon an open enqueue.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    // Extra wait in settle after the last expected result has arrived.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  count;
        logic              end_of_run;
        logic [LEN_W-1:0]  used_bytes;
        logic [LEN_W-1:0]  free_bytes;
        logic [LEN_W-1:0]  direct_enqueue;
        logic [LEN_W-1:0]  direct_dequeue;
    } ring_result_t;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // length[9:0], data_byte[17:10], zero pad
    logic [CMD_W-1:0]     s_tuser  = '0;   // command[2:0]
    logic                 s_tlast  = 1'b0; // last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // out_byte[7:0], count[17:8], used_bytes[27:18],
                                    // free_bytes[37:28], direct_enqueue[47:38],
                                    // direct_dequeue[57:48], zero pad
    logic                 m_tlast;  // end_of_run

    // Predicted ring state, updated at each accepted request.
    logic [BYTE_W-1:0] ring_mem [DEPTH];
    bit                ring_mem_valid [DEPTH];   // entry has been written at least once
    int unsigned       head_ptr;
    int unsigned       tail_ptr;
    bit                enq_open;
    bit                enq_ok;
    int unsigned       enq_written;
    int unsigned       enq_len;
    logic [CAP_W-1:0]  cap_reg = CAP_RESET;

    ring_result_t pending_results [$];
    int           mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  sent_items     = 0;
    int unsigned  src_idle_pct   = 0;
    int unsigned  sink_stall_pct = 0;

    byte_ring_buffer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Random backpressure on the result side.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------------------------------
    // Ring arithmetic on the predicted state
    // ---------------------------------------------------------------------------------------
    function automatic int unsigned ring_span();
        if (cap_reg < 2)
            return 2;
        if (cap_reg > DEPTH)
            return DEPTH;
        return cap_reg;
    endfunction

    function automatic int unsigned held_bytes();
        if (tail_ptr >= head_ptr)
            return tail_ptr - head_ptr;
        return ring_span() - head_ptr + tail_ptr;
    endfunction

    function automatic int unsigned room_bytes();
        return ring_span() - held_bytes() - 1;
    endfunction

    function automatic int unsigned step_ptr(input int unsigned p, input int unsigned by);
        return (p + by) % ring_span();
    endfunction

    // Number of bytes from the front that have real data behind them, up to one burst.
    function automatic int unsigned readable_run();
        int unsigned lim;
        int unsigned i;
        lim = (held_bytes() < MAX_BURST) ? held_bytes() : MAX_BURST;
        for (i = 0; i < lim; i++)
            if (!ring_mem_valid[step_ptr(head_ptr, i)])
                break;
        return i;
    endfunction

    function automatic void push_result(input int unsigned b, input int unsigned cnt,
                                        input int unsigned eor, input int unsigned u,
                                        input int unsigned f, input int unsigned de,
                                        input int unsigned dd);
        ring_result_t r;
        r.out_byte       = BYTE_W'(b);
        r.count          = LEN_W'(cnt);
        r.end_of_run     = eor[0];
        r.used_bytes     = LEN_W'(u);
        r.free_bytes     = LEN_W'(f);
        r.direct_enqueue = LEN_W'(de);
        r.direct_dequeue = LEN_W'(dd);
        pending_results.push_back(r);
    endfunction

    // Advance the predicted ring by one accepted request and queue what it must produce.
    function automatic void predict_request(input logic [CMD_W-1:0] cmd,
                                            input logic [LEN_W-1:0] len_f,
                                            input logic [BYTE_W-1:0] dat,
                                            input logic lst);
        int unsigned len;
        int unsigned n;
        int unsigned idx;
        int unsigned cnt;
        int unsigned u;
        int unsigned f;
        int unsigned de;
        int unsigned dd;
        len = len_f;
        n   = ring_span();
        // Anything but an enqueue byte drops a half-received enqueue
        if (cmd != CMD_ENQUEUE)
        begin
            enq_open    = 0;
            enq_ok      = 0;
            enq_written = 0;
        end
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (!enq_open)
                begin
                    enq_open    = 1;
                    enq_written = 0;
                    enq_len     = len;
                    enq_ok      = (room_bytes() >= len);
                end
                // Bytes past the announced length fall on the floor
                if (enq_ok && enq_written < enq_len)
                begin
                    idx                 = step_ptr(tail_ptr, enq_written);
                    ring_mem[idx]       = dat;
                    ring_mem_valid[idx] = 1;
                    enq_written++;
                end
                if (lst)
                begin
                    cnt         = enq_ok ? enq_written : 0;
                    tail_ptr    = step_ptr(tail_ptr, cnt);
                    enq_open    = 0;
                    enq_ok      = 0;
                    enq_written = 0;
                    push_result(0, cnt, 1, 0, 0, 0, 0);
                end
            end
            CMD_DEQUEUE, CMD_PEEK:
            begin
                if (len == 0 || len > MAX_BURST || len > held_bytes())
                    push_result(0, 0, 1, 0, 0, 0, 0);
                else
                begin
                    for (int unsigned i = 0; i < len; i++)
                        push_result(ring_mem[step_ptr(head_ptr, i)], len, (i + 1 == len),
                                    0, 0, 0, 0);
                    if (cmd == CMD_DEQUEUE)
                        head_ptr = step_ptr(head_ptr, len);
                end
            end
            CMD_MOVE_FRONT:
            begin
                head_ptr = step_ptr(head_ptr, len);
                push_result(0, len, 1, 0, 0, 0, 0);
            end
            CMD_MOVE_REAR:
            begin
                tail_ptr = step_ptr(tail_ptr, len);
                push_result(0, len, 1, 0, 0, 0, 0);
            end
            CMD_CLEAR:
            begin
                head_ptr = 0;
                tail_ptr = 0;
                push_result(0, 0, 1, 0, 0, 0, 0);
            end
            CMD_STATUS:
            begin
                u = held_bytes();
                f = room_bytes();
                // With the front at zero the reserved slot sits at the top of the ring
                if (tail_ptr >= head_ptr)
                    de = (head_ptr == 0) ? (n - tail_ptr - 1) : (n - tail_ptr);
                else
                    de = f;
                dd = (tail_ptr < head_ptr) ? (n - head_ptr) : u;
                push_result(0, 0, 1, u, f, de, dd);
            end
            default:
            begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------------------------
    // Result checking: every accepted result against the oldest prediction
    // ---------------------------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        ring_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: m_tdata %h m_tlast %b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, m_tdata[7:0]);
                check_field("count", want.count, m_tdata[17:8]);
                check_field("end_of_run", want.end_of_run, m_tlast);
                check_field("used_bytes", want.used_bytes, m_tdata[27:18]);
                check_field("free_bytes", want.free_bytes, m_tdata[37:28]);
                check_field("direct_enqueue", want.direct_enqueue, m_tdata[47:38]);
                check_field("direct_dequeue", want.direct_dequeue, m_tdata[57:48]);
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Drivers; every task starts and ends at a falling edge
    // ---------------------------------------------------------------------------------------
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] dat, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({dat, len});
        s_tuser  <= cmd;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(cmd, len, dat, lst);
        if (cmd != CMD_UNUSED)
            sent_items++;
        @(negedge clk);
    endtask

    // Length rides on the first byte only; later bytes carry noise there.
    task automatic send_enqueue(input int unsigned len, input int unsigned nbytes,
                                input bit close);
        for (int unsigned i = 0; i < nbytes; i++)
            send_request(CMD_ENQUEUE, (i == 0) ? LEN_W'(len) : LEN_W'($urandom),
                         BYTE_W'($urandom), close && (i + 1 == nbytes));
    endtask

    task automatic send_other(input logic [CMD_W-1:0] cmd, input int unsigned len);
        send_request(cmd, LEN_W'(len), BYTE_W'($urandom), 1'($urandom));
    endtask

    // Hold off until every result is in and any result-less work has had time to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_CAPACITY);
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // The write also drops both pointers and any open enqueue; the store keeps its bytes
        cap_reg     = CAP_W'(value);
        head_ptr    = 0;
        tail_ptr    = 0;
        enq_open    = 0;
        enq_ok      = 0;
        enq_written = 0;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------------------------------
    task automatic test_enqueue_and_read();
        send_request(CMD_ENQUEUE, 10'd3, 8'h00, 1'b0);
        send_request(CMD_ENQUEUE, 10'd0, 8'hFF, 1'b0);
        send_request(CMD_ENQUEUE, 10'd0, 8'h5A, 1'b1);
        send_other(CMD_STATUS, 0);
        send_other(CMD_PEEK, 3);
        send_other(CMD_DEQUEUE, 2);
        send_other(CMD_STATUS, 1023);
    endtask

    task automatic test_request_edges();
        send_enqueue(0, 1, 1);          // zero-length request commits nothing
        send_enqueue(4, 2, 1);          // last arrives early: commit what came
        send_enqueue(2, 3, 1);          // extra byte past the length is dropped
        send_enqueue(3, 1, 0);          // left open, then cut off by status
        send_other(CMD_STATUS, 0);
        send_enqueue(1023, 1, 1);       // longer than the free space: rejected
        send_other(CMD_UNUSED, 5);      // no result expected
    endtask

    task automatic test_read_rejects();
        send_other(CMD_DEQUEUE, 0);
        send_other(CMD_PEEK, MAX_BURST + 1);
        send_other(CMD_DEQUEUE, 1023);
        send_other(CMD_DEQUEUE, held_bytes() + 1);
        send_other(CMD_DEQUEUE, held_bytes());
    endtask

    task automatic test_pointer_moves();
        send_other(CMD_MOVE_FRONT, 0);
        send_other(CMD_MOVE_REAR, 1023);
        send_other(CMD_CLEAR, 1023);
    endtask

    // ---------------------------------------------------------------------------------------
    // Random traffic: mostly well-formed enqueue/read pairs, some broken requests and noise
    // ---------------------------------------------------------------------------------------
    task automatic test_random_traffic(input int unsigned cap, input int unsigned src_pct,
                                       input int unsigned snk_pct, input int unsigned n_items);
        int unsigned      goal;
        int unsigned      pick;
        int unsigned      room;
        int unsigned      hi;
        int unsigned      len;
        int unsigned      held;
        logic [CMD_W-1:0] cmd;
        settle();
        write_capacity(cap);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        goal = sent_items + n_items;
        while (sent_items < goal)
        begin
            pick = $urandom_range(0, 99);
            room = room_bytes();
            held = held_bytes();
            if (pick < 45)
            begin
                hi = ($urandom_range(0, 3) == 0) ? 70 : 10;
                if (hi > room)
                    hi = room;
                len = (hi == 0) ? $urandom_range(0, 2) : $urandom_range(1, hi);
                send_enqueue(len, (len == 0) ? 1 : len, 1);
            end
            else if (pick < 72)
            begin
                case ($urandom_range(0, 9))
                    0: len = 0;
                    1: len = $urandom_range(MAX_BURST + 1, 1023);
                    2: len = held + 1;
                    3: len = MAX_BURST;
                    default: len = $urandom_range(1, (held == 0) ? 1 :
                                                     (held < MAX_BURST) ? held : MAX_BURST);
                endcase
                // Keep a read that would succeed away from bytes never written
                if (len >= 1 && len <= MAX_BURST && len <= held && len > readable_run())
                    len = readable_run();
                cmd = ($urandom_range(0, 9) < 6) ? CMD_DEQUEUE : CMD_PEEK;
                send_other(cmd, len);
            end
            else if (pick < 80)
                send_other(CMD_STATUS, $urandom);
            else if (pick < 88)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        len = $urandom_range(2, 10);
                        send_enqueue(len, $urandom_range(1, len - 1), 1);
                    end
                    1:
                    begin
                        len = $urandom_range(0, 5);
                        send_enqueue(len, len + $urandom_range(1, 3), 1);
                    end
                    2:
                    begin
                        len = $urandom_range(2, 8);
                        send_enqueue(len, $urandom_range(1, len), 0);
                        send_other(CMD_STATUS, $urandom);
                    end
                    default:
                    begin
                        send_enqueue($urandom_range(room + 1, 1023), $urandom_range(1, 4), 1);
                    end
                endcase
            end
            else if (pick < 93)
            begin
                cmd = ($urandom_range(0, 1) == 0) ? CMD_MOVE_FRONT : CMD_MOVE_REAR;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 15);
                send_other(cmd, len);
            end
            else if (pick < 96)
                send_other(CMD_CLEAR, $urandom);
            else
                send_other(CMD_UNUSED, $urandom);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_enqueue_and_read();
        test_request_edges();
        test_read_rejects();
        test_pointer_moves();

        // Capacity values include both ends and the clamped ones below and above the range
        test_random_traffic(1024, 0, 0, 60);
        test_random_traffic(2, 67, 0, 35);
        test_random_traffic(37, 0, 67, 50);
        test_random_traffic(1, 35, 35, 25);
        test_random_traffic(2047, 35, 35, 45);
        test_random_traffic(129, 67, 67, 35);
        settle();

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

/* files.f */
rtl/brb_pkg.sv
rtl/byte_ring_buffer_core.sv
bench/tb.sv
